// ===== rtl/mrorb_pkg.sv =====
// Shared types for the multi-reader overwrite ring buffer.
// Holds the opcode encoding and the fixed port field widths; no dependencies.
`default_nettype none

package mrorb_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE       = 2'd0,
    OP_READ_OLDEST = 2'd1,
    OP_READ_NEWEST = 2'd2,
    OP_QUERY       = 2'd3
  } opcode_e;

endpackage

`default_nettype wire

// ===== rtl/mrorb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds when the read enable is low. No dependencies.
`default_nettype none

module mrorb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/multi_reader_overwrite_ring_buffer_top.sv =====
// Multi-reader overwrite ring buffer bank: top level.
// Uses mrorb_pkg (opcodes, field widths) and mrorb_ram (entry storage).
`default_nettype none

// A bank of NUM_BUFFERS circular buffers of DEPTH words each (DEPTH a power
// of two). Every buffer has one write pointer and one read pointer per client.
// Operations: write (stores a word; any client whose read pointer sits on the
// next write slot loses its oldest entry, so writers never stall), read oldest,
// read newest (client skips to the most recent entry and catches up), and
// query (pending count, at most DEPTH-1). Out-of-range buffer or client gives
// an all-zero result with no state change; writes ignore client_id.
// Throughput is one item per cycle while the output is not held; each result
// appears in the cycle after its item is accepted, through the registered read
// of the single entry RAM (one write and one read port, NUM_BUFFERS*DEPTH words);
// pointer updates and collision compares finish in the accept cycle. A result
// waits in the output register, and a new item is taken in the cycle the result leaves.
// Entry storage is not cleared at reset; only written entries are ever read.

module multi_reader_overwrite_ring_buffer_top #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned NUM_CLIENTS = 4,
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input item channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [mrorb_pkg::OPCODE_W-1:0]      opcode_i,
  input  wire logic [mrorb_pkg::INDEX_W-1:0]       buffer_index_i,
  input  wire logic [mrorb_pkg::INDEX_W-1:0]       client_id_i,
  input  wire logic [mrorb_pkg::WORD_W-1:0]        write_data_i,
  // result item channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     has_data_o,
  output logic      [mrorb_pkg::WORD_W-1:0]        read_data_o,
  output logic      [mrorb_pkg::COUNT_W-1:0]       pending_count_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned RDEPTH = NUM_BUFFERS * DEPTH;
  localparam int unsigned ADDR_W = $clog2(RDEPTH);

  // pointer state
  logic [NUM_BUFFERS-1:0][PTR_W-1:0]                  wp_q, wp_d;
  logic [NUM_BUFFERS-1:0][NUM_CLIENTS-1:0][PTR_W-1:0] rp_q, rp_d;

  // result register (data word lives in the RAM read register)
  logic             out_valid_q, out_valid_d;
  logic             has_q, has_d;
  logic [PTR_W-1:0] count_q, count_d;

  mrorb_pkg::opcode_e op;
  logic               accept;
  logic               buf_ok, cli_ok;
  logic [PTR_W-1:0]   wp_sel, rp_sel, count, rd_ptr;
  logic               is_write, is_query, is_newest, is_read;
  logic               do_write, do_read;

  logic [BUF_W+1:0]       bidx_ext;
  logic [BUF_W-1:0]       bsel;
  logic [BUF_W+PTR_W-1:0] waddr_full, raddr_full;

  logic [DATA_WIDTH+mrorb_pkg::WORD_W-1:0] wd_ext, rd_ext;
  logic [DATA_WIDTH-1:0]                   ram_wdata, ram_rdata;
  logic [PTR_W+mrorb_pkg::COUNT_W-1:0]     cnt_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign op        = mrorb_pkg::opcode_e'(opcode_i);
  assign is_write  = (op == mrorb_pkg::OP_WRITE);
  assign is_query  = (op == mrorb_pkg::OP_QUERY);
  assign is_newest = (op == mrorb_pkg::OP_READ_NEWEST);
  assign is_read   = (op == mrorb_pkg::OP_READ_OLDEST) || is_newest;

  // select the target buffer's pointers; a miss marks the index out of range
  always_comb begin
    buf_ok = 1'b0;
    cli_ok = 1'b0;
    wp_sel = '0;
    rp_sel = '0;
    for (int b = 0; b < NUM_BUFFERS; b++) begin
      if (32'(buffer_index_i) == b) begin
        buf_ok = 1'b1;
        wp_sel = wp_q[b];
        for (int c = 0; c < NUM_CLIENTS; c++) begin
          if (32'(client_id_i) == c) begin
            cli_ok = 1'b1;
            rp_sel = rp_q[b][c];
          end
        end
      end
    end
  end

  assign count    = wp_sel - rp_sel;
  assign rd_ptr   = is_newest ? (wp_sel - PTR_W'(1)) : rp_sel;
  assign do_write = accept && buf_ok && is_write;
  assign do_read  = accept && buf_ok && cli_ok && is_read && (count != '0);

  // pointer next state
  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    for (int b = 0; b < NUM_BUFFERS; b++) begin
      if (32'(buffer_index_i) == b) begin
        if (do_write) begin
          wp_d[b] = wp_q[b] + PTR_W'(1);
          // clients sitting on the slot after the one being written drop one
          for (int c = 0; c < NUM_CLIENTS; c++) begin
            if (rp_q[b][c] == wp_q[b] + PTR_W'(1)) begin
              rp_d[b][c] = rp_q[b][c] + PTR_W'(1);
            end
          end
        end
        for (int c = 0; c < NUM_CLIENTS; c++) begin
          if (do_read && (32'(client_id_i) == c)) begin
            rp_d[b][c] = rd_ptr + PTR_W'(1);
          end
        end
      end
    end
  end

  // result fields
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  assign has_d   = do_read;
  assign count_d = (buf_ok && cli_ok && !is_write && (is_query || count != '0)) ? count : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      has_q   <= has_d;
      count_q <= count_d;
    end
  end

  // entry RAM: address is {buffer, slot}
  assign bidx_ext   = {{BUF_W{1'b0}}, buffer_index_i};
  assign bsel       = bidx_ext[BUF_W-1:0];
  assign waddr_full = {bsel, wp_sel};
  assign raddr_full = {bsel, rd_ptr};
  assign wd_ext     = {{DATA_WIDTH{1'b0}}, write_data_i};
  assign ram_wdata  = wd_ext[DATA_WIDTH-1:0];

  mrorb_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(RDEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(waddr_full[ADDR_W-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (do_read),
    .raddr_i(raddr_full[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_ext  = {{mrorb_pkg::WORD_W{1'b0}}, ram_rdata};
  assign cnt_ext = {{mrorb_pkg::COUNT_W{1'b0}}, count_q};

  assign out_valid_o     = out_valid_q;
  assign has_data_o      = has_q;
  assign read_data_o     = has_q ? rd_ext[mrorb_pkg::WORD_W-1:0] : '0;
  assign pending_count_o = cnt_ext[mrorb_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire
